>>> rtl/aesir_pkg.sv
package aesir_pkg;

    localparam int ROWS = 4;

    typedef logic [7:0] byte_t;
    typedef logic [127:0] block_t;

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    function automatic byte_t xtime(byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic byte_t get_byte(block_t b, int idx);
        return b[127 - 8 * idx -: 8];
    endfunction

endpackage

>>> rtl/aesir_sub_shift.sv
module aesir_sub_shift #(
    parameter int COLUMNS = 4
) (
    input  logic [8*aesir_pkg::ROWS*COLUMNS-1:0] state_in,
    input  logic [8*aesir_pkg::ROWS*COLUMNS-1:0] round_key,
    output logic [8*aesir_pkg::ROWS*COLUMNS-1:0] state_out
);

    localparam int NB = aesir_pkg::ROWS * COLUMNS;

    always_comb begin
        for (int c = 0; c < COLUMNS; c++) begin
            for (int r = 0; r < aesir_pkg::ROWS; r++) begin
                state_out[8*NB - 1 - 8*(c*aesir_pkg::ROWS + r) -: 8] =
                    aesir_pkg::INV_SBOX[state_in[8*NB - 1
                        - 8*(((c - r + COLUMNS) % COLUMNS)*aesir_pkg::ROWS + r) -: 8]]
                    ^ round_key[8*NB - 1 - 8*(c*aesir_pkg::ROWS + r) -: 8];
            end
        end
    end

endmodule

>>> rtl/aesir_mix.sv
module aesir_mix #(
    parameter int COLUMNS = 4
) (
    input  logic [8*aesir_pkg::ROWS*COLUMNS-1:0] state_in,
    output logic [8*aesir_pkg::ROWS*COLUMNS-1:0] state_out
);

    localparam int NB = aesir_pkg::ROWS * COLUMNS;

    function automatic aesir_pkg::byte_t mul_e(aesir_pkg::byte_t a);
        aesir_pkg::byte_t a2, a4, a8;
        a2 = aesir_pkg::xtime(a);
        a4 = aesir_pkg::xtime(a2);
        a8 = aesir_pkg::xtime(a4);
        return a8 ^ a4 ^ a2;
    endfunction

    function automatic aesir_pkg::byte_t mul_b(aesir_pkg::byte_t a);
        aesir_pkg::byte_t a2, a8;
        a2 = aesir_pkg::xtime(a);
        a8 = aesir_pkg::xtime(aesir_pkg::xtime(a2));
        return a8 ^ a2 ^ a;
    endfunction

    function automatic aesir_pkg::byte_t mul_d(aesir_pkg::byte_t a);
        aesir_pkg::byte_t a4, a8;
        a4 = aesir_pkg::xtime(aesir_pkg::xtime(a));
        a8 = aesir_pkg::xtime(a4);
        return a8 ^ a4 ^ a;
    endfunction

    function automatic aesir_pkg::byte_t mul_9(aesir_pkg::byte_t a);
        aesir_pkg::byte_t a8;
        a8 = aesir_pkg::xtime(aesir_pkg::xtime(aesir_pkg::xtime(a)));
        return a8 ^ a;
    endfunction

    always_comb begin
        for (int c = 0; c < COLUMNS; c++) begin
            for (int r = 0; r < aesir_pkg::ROWS; r++) begin
                state_out[8*NB - 1 - 8*(c*aesir_pkg::ROWS + r) -: 8] =
                    mul_e(state_in[8*NB - 1 - 8*(c*4 + r) -: 8])
                    ^ mul_b(state_in[8*NB - 1 - 8*(c*4 + (r + 1) % 4) -: 8])
                    ^ mul_d(state_in[8*NB - 1 - 8*(c*4 + (r + 2) % 4) -: 8])
                    ^ mul_9(state_in[8*NB - 1 - 8*(c*4 + (r + 3) % 4) -: 8]);
            end
        end
    end

endmodule

>>> rtl/aes_inverse_round.sv
// one aes inverse cipher round: inv shift rows, inv sub bytes, add round key,
// inv mix columns
// input channel s_axis: tdata carries state_in_hi, state_in_lo, round_key_hi,
// round_key_lo from the lowest bit up, 256 bits
// output channel m_axis: tdata carries state_out_hi, state_out_lo, 128 bits
// datapath: the request is held in an input register, the round logic runs
// combinationally into the output register, which drives m_axis_tvalid and
// m_axis_tdata
// throughput is one request per cycle while m_axis_tready is high; both registers advance together
// whenever the output register is empty or being taken
// a stall on m_axis_tready holds both stages and drops s_axis_tready once
// both are full, so nothing is lost
// reset clears both valid flags; no data is flushed or produced
module aes_inverse_round #(
    parameter int COLUMNS = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // state_in_hi, state_in_lo, round_key_hi, round_key_lo
    input  logic [255:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // state_out_hi, state_out_lo
    output logic [127:0] m_axis_tdata
);

    localparam int W = 8 * aesir_pkg::ROWS * COLUMNS;

    logic         in_valid_reg;
    logic [W-1:0] in_state_reg;
    logic [W-1:0] in_key_reg;
    logic         out_valid_reg;
    logic [127:0] out_data_reg;
    logic         advance;
    logic [W-1:0] sub_state;
    logic [W-1:0] mix_state;

    assign advance = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance || !in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready) begin
            in_state_reg <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
            in_key_reg   <= {s_axis_tdata[191:128], s_axis_tdata[255:192]};
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= {mix_state[63:0], mix_state[127:64]};
        end
    end

    aesir_sub_shift #(.COLUMNS(COLUMNS)) u_sub_shift (
        .state_in  (in_state_reg),
        .round_key (in_key_reg),
        .state_out (sub_state)
    );

    aesir_mix #(.COLUMNS(COLUMNS)) u_mix (
        .state_in  (sub_state),
        .state_out (mix_state)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> rtl/aesir_checker.sv
module aesir_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // a held output keeps its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // free output means input is always taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // an accepted request shows up at the output when never stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid)
        else $error("request lost");

    // nothing appears without an earlier request
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid, 2) || $past(s_axis_tvalid, 1)
            || $past(m_axis_tvalid, 1))
        else $error("output without request");

endmodule

bind aes_inverse_round aesir_checker u_checker (.*);
